FILE: src/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define VNA_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("vna: assertion failed");

// Antecedent in this cycle implies consequent in the next cycle.
`define VNA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vna: assertion failed");

`endif

FILE: src/vna_pkg.sv
// Types and constants of the vertex normal accumulator.
`default_nettype none

package vna_pkg;

	localparam int SUM_W  = 26;  // running sum, signed Q1.14 with headroom
	localparam int CNT_W  = 10;  // edge counter
	localparam int SQ_W   = 62;  // sum of three squares
	localparam int ROOT_W = 32;  // vector length
	localparam int NUM_W  = 45;  // dividend m * 2^14 + len / 2
	localparam int QUOT_W = 15;  // quotient bits, never above 2^14

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_ZERO  = 2'd1;
	localparam logic [1:0] STATUS_LIMIT = 2'd2;

	typedef struct packed {
		logic               has_face;
		logic signed [31:0] p0_x;
		logic signed [31:0] p0_y;
		logic signed [31:0] p0_z;
		logic signed [31:0] p1_x;
		logic signed [31:0] p1_y;
		logic signed [31:0] p1_z;
		logic signed [31:0] p2_x;
		logic signed [31:0] p2_y;
		logic signed [31:0] p2_z;
		logic               last_edge;
	} item_t;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic [1:0]         status;
	} res_t;

endpackage

`default_nettype wire

FILE: src/vna_mul.sv
// Shared registered 32 x 32 signed multiplier.
`default_nettype none

module vna_mul (
	input  logic               clk,
	input  logic signed [31:0] op_a,
	input  logic signed [31:0] op_b,
	output logic signed [63:0] prod
);

	logic signed [63:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

FILE: src/vna_sqrt.sv
// Iterative integer square root, one result bit per cycle.
`default_nettype none

module vna_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [vna_pkg::SQ_W-1:0]    radicand,
	output logic                        done,
	output logic [vna_pkg::ROOT_W-1:0]  root
);

	import vna_pkg::*;

	logic [SQ_W-1:0] n_q;
	logic [63:0]     r_q;
	logic [63:0]     bit_q;
	logic            busy_q;
	logic            done_q;
	logic [63:0]     trial;
	logic            ge;

	assign trial = r_q + bit_q;
	assign ge    = 64'(n_q) >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			r_q    <= '0;
			bit_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q & bit_q[0];
			if (start) begin
				n_q    <= radicand;
				r_q    <= '0;
				bit_q  <= 64'(1) << 62;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ge) begin
					n_q <= n_q - trial[SQ_W-1:0];
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign root = r_q[ROOT_W-1:0];

endmodule

`default_nettype wire

FILE: src/vna_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module vna_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [vna_pkg::NUM_W-1:0]   num,
	input  logic [vna_pkg::ROOT_W-1:0]  den,
	output logic                        done,
	output logic [vna_pkg::QUOT_W-1:0]  quot
);

	import vna_pkg::*;

	// quotient is known to fit QUOT_W bits, so the top of num starts below den
	logic [ROOT_W-1:0] rem_q;
	logic [QUOT_W-1:0] q_q;
	logic [3:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W:0]   trial;
	logic              ge;

	assign trial = {rem_q, q_q[QUOT_W-1]};
	assign ge    = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			q_q    <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 4'd1);
			if (start) begin
				rem_q  <= ROOT_W'(num[NUM_W-1:QUOT_W]);
				q_q    <= num[QUOT_W-1:0];
				cnt_q  <= 4'(QUOT_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= ROOT_W'(trial - {1'b0, den});
				end else begin
					rem_q <= trial[ROOT_W-1:0];
				end
				q_q   <= {q_q[QUOT_W-2:0], ge};
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

`default_nettype wire

FILE: src/vertex_normal_accumulator.sv
// Top level: vertex normal accumulator sequencer and datapath.
// An item without a face (or past the edge limit) that is not last is taken without leaving idle.
// A face item runs through 6 shared multiplies, up to 10 normalising
// shift steps, 3 squares, 32 square-root steps and 3 divides of 15 steps each.
// A last item adds a normalise pass on the sum (a limit status instead past the edge limit), then the result goes out.
// Asynchronous active-low reset clears sum, count, limit flag and all control state.
`default_nettype none

module vertex_normal_accumulator #(
	parameter int EDGE_LIMIT = 500
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  vna_pkg::item_t item,
	output logic           res_valid,
	input  logic           res_stall,
	output vna_pkg::res_t  res
);

	import vna_pkg::*;

	localparam logic [CNT_W-1:0] MAX_E = CNT_W'(EDGE_LIMIT);

	// magnitude bounds for the normalising shift loop
	localparam logic [SQ_W-1:0] LIM38 = SQ_W'(1) << 38;
	localparam logic [SQ_W-1:0] LIM30 = SQ_W'(1) << 30;
	localparam logic [SQ_W-1:0] LIM29 = SQ_W'(1) << 29;
	localparam logic [SQ_W-1:0] LIM21 = SQ_W'(1) << 21;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIFF, ST_FIT, ST_MUL, ST_MAG, ST_MAX, ST_SHIFT,
		ST_SQ, ST_SQRT, ST_DIV, ST_ACC, ST_FINAL, ST_OUT
	} state_t;

	state_t state_q;

	item_t                    item_q;
	logic signed [SUM_W-1:0]  sum_q [3];
	logic [CNT_W-1:0]         cnt_q;
	logic                     ovf_q;
	logic                     mode_sum_q;   // normalising the sum, not a face
	logic signed [32:0]       da_q [3];
	logic signed [32:0]       db_q [3];
	logic signed [31:0]       a_q [3];
	logic signed [31:0]       b_q [3];
	logic [2:0]               k_q;
	logic signed [63:0]       c_q [3];
	logic [SQ_W-1:0]          m_q [3];
	logic                     neg_q [3];
	logic [SQ_W-1:0]          mx_q;
	logic [SQ_W-1:0]          sq_q;
	logic [ROOT_W-1:0]        len_q;
	logic signed [15:0]       n_q [3];
	logic [1:0]               didx_q;
	logic                     zero_q;
	logic                     sqrt_start_q;
	logic                     div_start_q;
	res_t                     res_q;
	logic                     res_valid_q;
	res_t                     res_out_q;

	logic signed [31:0]       mul_a, mul_b;
	logic signed [63:0]       prod;
	logic                     sqrt_done;
	logic [ROOT_W-1:0]        sqrt_root;
	logic                     div_done;
	logic [QUOT_W-1:0]        div_quot;
	logic [NUM_W-1:0]         div_num;

	logic signed [31:0]       p0 [3];
	logic signed [31:0]       p1 [3];
	logic signed [31:0]       p2 [3];
	logic signed [31:0]       fa [3];
	logic signed [31:0]       fb [3];
	logic [SQ_W-1:0]          mx_c;
	logic [2:0]               pidx;
	logic                     cnt_ge;
	logic                     ovf_n;

	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

	// least right shift that brings the largest magnitude to 2^30 or less
	function automatic logic [1:0] fit_k(input logic [32:0] mx);
		if (mx <= 33'h0_4000_0000) begin
			return 2'd0;
		end else if (mx <= 33'h0_8000_0001) begin
			return 2'd1;
		end
		return 2'd2;
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
		input logic signed [15:0] d);
		logic signed [SUM_W:0] r;
		r = (SUM_W+1)'(s) + (SUM_W+1)'(d);
		if (r > 27'sd33554431) begin
			return 26'sh1FFFFFF;
		end else if (r < -27'sd33554432) begin
			return 26'sh2000000;
		end
		return r[SUM_W-1:0];
	endfunction

	assign p0[0] = item_q.p0_x;
	assign p0[1] = item_q.p0_y;
	assign p0[2] = item_q.p0_z;
	assign p1[0] = item_q.p1_x;
	assign p1[1] = item_q.p1_y;
	assign p1[2] = item_q.p1_z;
	assign p2[0] = item_q.p2_x;
	assign p2[1] = item_q.p2_y;
	assign p2[2] = item_q.p2_z;

	// fit both edge vectors into 31-bit magnitudes
	always_comb begin
		logic [32:0] ma [3];
		logic [32:0] mb [3];
		logic [32:0] mxa, mxb, sha, shb;
		logic [1:0]  ka, kb;
		for (int i = 0; i < 3; i++) begin
			ma[i] = mag33(da_q[i]);
			mb[i] = mag33(db_q[i]);
		end
		mxa = ma[0];
		mxb = mb[0];
		for (int i = 1; i < 3; i++) begin
			if (ma[i] > mxa) mxa = ma[i];
			if (mb[i] > mxb) mxb = mb[i];
		end
		ka = fit_k(mxa);
		kb = fit_k(mxb);
		for (int i = 0; i < 3; i++) begin
			sha   = ma[i] >> ka;
			shb   = mb[i] >> kb;
			fa[i] = da_q[i][32] ? -$signed(sha[31:0]) : $signed(sha[31:0]);
			fb[i] = db_q[i][32] ? -$signed(shb[31:0]) : $signed(shb[31:0]);
		end
	end

	always_comb begin
		mx_c = m_q[0];
		if (m_q[1] > mx_c) mx_c = m_q[1];
		if (m_q[2] > mx_c) mx_c = m_q[2];
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL: begin
				case (k_q)
					3'd0: begin mul_a = a_q[1]; mul_b = b_q[2]; end
					3'd1: begin mul_a = a_q[2]; mul_b = b_q[1]; end
					3'd2: begin mul_a = a_q[2]; mul_b = b_q[0]; end
					3'd3: begin mul_a = a_q[0]; mul_b = b_q[2]; end
					3'd4: begin mul_a = a_q[0]; mul_b = b_q[1]; end
					3'd5: begin mul_a = a_q[1]; mul_b = b_q[0]; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			ST_SQ: begin
				if (k_q < 3'd3) begin
					mul_a = $signed({1'b0, m_q[k_q[1:0]][30:0]});
					mul_b = $signed({1'b0, m_q[k_q[1:0]][30:0]});
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign pidx    = k_q - 3'd1;
	assign div_num = NUM_W'({m_q[didx_q][30:0], 14'b0}) + NUM_W'(len_q[ROOT_W-1:1]);
	assign cnt_ge  = cnt_q >= MAX_E;
	assign ovf_n   = ovf_q | cnt_ge;

	vna_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	vna_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start_q),
		.radicand (sq_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	vna_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num),
		.den    (len_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			item_q       <= '0;
			cnt_q        <= '0;
			ovf_q        <= 1'b0;
			mode_sum_q   <= 1'b0;
			k_q          <= '0;
			mx_q         <= '0;
			sq_q         <= '0;
			len_q        <= '0;
			didx_q       <= '0;
			zero_q       <= 1'b0;
			sqrt_start_q <= 1'b0;
			div_start_q  <= 1'b0;
			res_q        <= '0;
			res_valid_q  <= 1'b0;
			res_out_q    <= '0;
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
				da_q[i]  <= '0;
				db_q[i]  <= '0;
				a_q[i]   <= '0;
				b_q[i]   <= '0;
				c_q[i]   <= '0;
				m_q[i]   <= '0;
				neg_q[i] <= 1'b0;
				n_q[i]   <= '0;
			end
		end else begin
			sqrt_start_q <= 1'b0;
			div_start_q  <= 1'b0;
			// in ST_OUT the output register is reloaded instead
			if (res_valid_q && !res_stall && (state_q != ST_OUT)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						item_q     <= item;
						mode_sum_q <= 1'b0;
						ovf_q      <= ovf_n;
						if (!cnt_ge) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (item.has_face && !ovf_n) begin
							state_q <= ST_DIFF;
						end else if (item.last_edge) begin
							state_q <= ST_FINAL;
						end
					end
				end
				ST_DIFF: begin
					for (int i = 0; i < 3; i++) begin
						da_q[i] <= 33'(p2[i]) - 33'(p1[i]);
						db_q[i] <= 33'(p0[i]) - 33'(p1[i]);
					end
					state_q <= ST_FIT;
				end
				ST_FIT: begin
					for (int i = 0; i < 3; i++) begin
						a_q[i] <= fa[i];
						b_q[i] <= fb[i];
					end
					k_q     <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					// product of the previous pair lands now; odd pairs subtract
					if (k_q != 3'd0) begin
						if (pidx[0]) begin
							c_q[pidx[2:1]] <= c_q[pidx[2:1]] - prod;
						end else begin
							c_q[pidx[2:1]] <= prod;
						end
					end
					if (k_q == 3'd6) begin
						state_q <= ST_MAG;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				ST_MAG: begin
					for (int i = 0; i < 3; i++) begin
						m_q[i]   <= c_q[i][63] ? SQ_W'(-c_q[i]) : SQ_W'(c_q[i]);
						neg_q[i] <= c_q[i][63];
					end
					state_q <= ST_MAX;
				end
				ST_MAX: begin
					mx_q <= mx_c;
					if (mx_c == '0) begin
						zero_q  <= 1'b1;
						for (int i = 0; i < 3; i++) begin
							n_q[i] <= '0;
						end
						state_q <= ST_ACC;
					end else begin
						zero_q  <= 1'b0;
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					// bring the largest magnitude into [2^29, 2^30]
					if (mx_q > LIM38) begin
						mx_q <= mx_q >> 8;
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 8;
					end else if (mx_q > LIM30) begin
						mx_q <= mx_q >> 1;
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
					end else if (mx_q < LIM21) begin
						mx_q <= mx_q << 8;
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 8;
					end else if (mx_q < LIM29) begin
						mx_q <= mx_q << 1;
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
					end else begin
						k_q     <= '0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (k_q == 3'd1) begin
						sq_q <= prod[SQ_W-1:0];
					end else if (k_q != 3'd0) begin
						sq_q <= sq_q + prod[SQ_W-1:0];
					end
					if (k_q == 3'd3) begin
						sqrt_start_q <= 1'b1;
						state_q      <= ST_SQRT;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				ST_SQRT: begin
					if (sqrt_done) begin
						len_q       <= sqrt_root;
						didx_q      <= '0;
						div_start_q <= 1'b1;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						n_q[didx_q] <= neg_q[didx_q] ? -$signed({1'b0, div_quot})
							: $signed({1'b0, div_quot});
						if (didx_q == 2'd2) begin
							state_q <= ST_ACC;
						end else begin
							didx_q      <= didx_q + 2'd1;
							div_start_q <= 1'b1;
						end
					end
				end
				ST_ACC: begin
					if (mode_sum_q) begin
						res_q.normal_x <= n_q[0];
						res_q.normal_y <= n_q[1];
						res_q.normal_z <= n_q[2];
						res_q.status   <= zero_q ? STATUS_ZERO : STATUS_OK;
						state_q        <= ST_OUT;
					end else begin
						for (int i = 0; i < 3; i++) begin
							sum_q[i] <= sat_add(sum_q[i], n_q[i]);
						end
						state_q <= item_q.last_edge ? ST_FINAL : ST_IDLE;
					end
				end
				ST_FINAL: begin
					if (ovf_q) begin
						res_q.normal_x <= '0;
						res_q.normal_y <= '0;
						res_q.normal_z <= '0;
						res_q.status   <= STATUS_LIMIT;
						state_q        <= ST_OUT;
					end else begin
						for (int i = 0; i < 3; i++) begin
							c_q[i] <= 64'(sum_q[i]);
						end
						mode_sum_q <= 1'b1;
						state_q    <= ST_MAG;
					end
				end
				ST_OUT: begin
					// hand over once the output register is free, then clear per-vertex state
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						res_out_q   <= res_q;
						cnt_q       <= '0;
						ovf_q       <= 1'b0;
						mode_sum_q  <= 1'b0;
						for (int i = 0; i < 3; i++) begin
							sum_q[i] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item_stall = (state_q != ST_IDLE);
	assign res_valid  = res_valid_q;
	assign res        = res_out_q;

endmodule

`default_nettype wire

FILE: src/vna_checker.sv
// Port-level checker for the vertex normal accumulator, with its bind.
`default_nettype none

`include "assert_macros.svh"

module vna_props (
	input logic           clk,
	input logic           arst_n,
	input logic           item_valid,
	input logic           item_stall,
	input vna_pkg::item_t item,
	input logic           res_valid,
	input logic           res_stall,
	input vna_pkg::res_t  res
);

	import vna_pkg::*;

	logic take_last;
	logic norm_zero;

	assign take_last = item_valid && !item_stall && item.last_edge;
	assign norm_zero = (res.normal_x == 16'sd0) && (res.normal_y == 16'sd0)
		&& (res.normal_z == 16'sd0);

	`VNA_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid)
	`VNA_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && res_stall, $stable(res))
	`VNA_ASSERT_NEXT(a_last_busy, clk, arst_n, take_last, item_stall)
	`VNA_ASSERT(a_status_code, clk, arst_n, !res_valid || (res.status <= STATUS_LIMIT))
	`VNA_ASSERT(a_fail_zero, clk, arst_n, !res_valid || (res.status == STATUS_OK) || norm_zero)

endmodule

bind vertex_normal_accumulator vna_props u_vna_props (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_stall (item_stall),
	.item       (item),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res        (res)
);

`default_nettype wire
